// ----- src/mlpt_pkg.sv -----
// ----------------------------------------------------------------------------
// mlpt_pkg: shared types, constants and fixed point helpers
// Holds the Q16.16 arithmetic helpers, the tanh sample table and the
// weight memory request type used by the network trainer.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpt_pkg;

  localparam int TANH_DEPTH = 256;
  localparam int TANH_SH    = $clog2(TANH_DEPTH);
  localparam int WIDX_W     = 9;

  localparam logic signed [31:0] ONE_Q16  = 32'sd65536;
  localparam logic signed [31:0] FOUR_Q16 = 32'sd262144;

  typedef logic signed [31:0] word_t;
  typedef word_t tanh_tbl_t [TANH_DEPTH];

  typedef struct packed {
    logic              we;
    logic [WIDX_W-1:0] waddr;
    word_t             wdata;
    logic [WIDX_W-1:0] raddr;
  } wram_req_t;

  function automatic word_t sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic word_t qadd(input word_t a, input word_t b);
    return sat32(48'(a) + 48'(b));
  endfunction

  function automatic word_t qsub(input word_t a, input word_t b);
    return sat32(48'(a) - 48'(b));
  endfunction

  // Rounds a full 64-bit product back to Q16.16 (floor of value plus half).
  function automatic word_t qpost(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = (p + 64'sd32768) >>> 16;
    return sat32(s[47:0]);
  endfunction

  // Restoring long division; only evaluated while the tanh table is built.
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned quo;
    logic [64:0]     rem;
    quo = '0;
    rem = '0;
    for (int bi = 63; bi >= 0; bi--) begin
      rem = {rem[63:0], n[bi]};
      if (rem >= {1'b0, d}) begin
        rem     = rem - {1'b0, d};
        quo[bi] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic tanh_tbl_t build_tanh();
    tanh_tbl_t         tbl;
    longint unsigned   term, sum, q, r, b, num, den, t;
    int                m;
    int unsigned       e;
    int                i, k;
    term = 64'd1 << 60;
    sum  = term;
    for (i = 1; i <= 20; i++) begin
      term = udiv64(term * 64'd8, 64'(i) * 64'(TANH_DEPTH));
      if (i[0]) sum = sum - term;
      else sum = sum + term;
    end
    q = (sum + (64'd1 << 29)) >> 30;
    for (k = 0; k < TANH_DEPTH; k++) begin
      m = 2 * k - TANH_DEPTH;
      e = (m < 0) ? -m : m;
      r = 64'd1 << 30;
      b = q;
      while (e != 0) begin
        if (e[0]) r = (r * b + (64'd1 << 29)) >> 30;
        b = (b * b + (64'd1 << 29)) >> 30;
        e = e >> 1;
      end
      num = ((64'd1 << 30) - r) << 16;
      den = (64'd1 << 30) + r;
      t   = udiv64(num + (den >> 1), den);
      tbl[k] = (m < 0) ? -signed'(t[31:0]) : signed'(t[31:0]);
    end
    return tbl;
  endfunction

  localparam tanh_tbl_t TANH_TBL = build_tanh();

endpackage

`default_nettype wire

// ----- src/mlpt_wram.sv -----
// ----------------------------------------------------------------------------
// mlpt_wram: weight and bias store
// One write and one registered read port. Per-entry valid bits make
// entries read as zero until they are first written after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpt_wram #(
  parameter int DEPTH = 151
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire mlpt_pkg::wram_req_t req,
  output mlpt_pkg::word_t          rdata
);
  import mlpt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  word_t            mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  word_t            rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    rdata_r <= mem[req.raddr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr[AW-1:0]] <= 1'b1;
      end
      rvld_r <= vld_r[req.raddr[AW-1:0]];
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

`default_nettype wire

// ----- src/mlp_tanh_sgd_train_step_top.sv -----
// ----------------------------------------------------------------------------
// mlp_tanh_sgd_train_step_top: two-layer tanh network with SGD training
// Sequenced datapath around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// A transaction carries one operation. Every multiply of the network goes
// through one shared 32x32 multiplier under a sequencer, and each step also
// waits for the registered read of the weight memory, so the run time of a
// predict or a train step follows the number of multiplies. A hidden sum
// outside the tanh table skips the interpolation. The input stalls from
// acceptance until the result sits in the output register; a result that
// waits there does not hold back acceptance of the next transaction, but
// that transaction cannot finish until the waiting result is taken.
`default_nettype none

module mlp_tanh_sgd_train_step_top #(
  parameter int HIDDEN   = 30,
  parameter int FEATURES = 3
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_wr_en,
  input  wire [16:0]             cfg_wr_data,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire [1:0]              in_op,
  input  wire signed [31:0]      in_feature_a,
  input  wire signed [31:0]      in_feature_b,
  input  wire signed [31:0]      in_feature_c,
  input  wire signed [31:0]      in_target,
  input  wire [8:0]              in_weight_index,
  input  wire signed [31:0]      in_weight_value,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic signed [31:0]     out_prediction,
  output logic [30:0]            out_squared_error,
  output logic signed [31:0]     out_read_value,
  output logic                   out_index_bad
);
  import mlpt_pkg::*;

  localparam int WORDS  = FEATURES * HIDDEN + 2 * HIDDEN + 1;
  localparam int HW     = (HIDDEN > 1) ? $clog2(HIDDEN) : 1;
  localparam int OFS_B  = FEATURES * HIDDEN;
  localparam int OFS_O  = OFS_B + HIDDEN;
  localparam int OFS_OB = OFS_O + HIDDEN;

  typedef enum logic [35:0] {
    S_IDLE   = 36'd1 << 0,  S_HB_RD  = 36'd1 << 1,  S_HB_LD  = 36'd1 << 2,
    S_HW_RD  = 36'd1 << 3,  S_HW_MUL = 36'd1 << 4,  S_HW_ACC = 36'd1 << 5,
    S_T_IDX  = 36'd1 << 6,  S_T_MUL  = 36'd1 << 7,  S_T_ADD  = 36'd1 << 8,
    S_T_WR   = 36'd1 << 9,  S_OB_RD  = 36'd1 << 10, S_OB_LD  = 36'd1 << 11,
    S_OW_RD  = 36'd1 << 12, S_OW_MUL = 36'd1 << 13, S_OW_ACC = 36'd1 << 14,
    S_ERR    = 36'd1 << 15, S_SQ_MUL = 36'd1 << 16, S_SQ     = 36'd1 << 17,
    S_U_RD   = 36'd1 << 18, S_U_HE   = 36'd1 << 19, S_U_HE2  = 36'd1 << 20,
    S_U_DV   = 36'd1 << 21, S_U_GO   = 36'd1 << 22, S_U_HD   = 36'd1 << 23,
    S_U_OW   = 36'd1 << 24, S_U_BW   = 36'd1 << 25, S_U_IRD  = 36'd1 << 26,
    S_U_IM1  = 36'd1 << 27, S_U_IM2  = 36'd1 << 28, S_U_IWR  = 36'd1 << 29,
    S_U_OB   = 36'd1 << 30, S_U_OBW  = 36'd1 << 31, S_WR     = 36'd1 << 32,
    S_RRD    = 36'd1 << 33, S_RLD    = 36'd1 << 34, S_DONE   = 36'd1 << 35
  } state_t;

  state_t state_r, state_nxt;

  logic [16:0]       lr_r;
  logic [1:0]        op_r;
  word_t             x_r [3];
  word_t             target_r;
  logic [8:0]        widx_r;
  word_t             wval_r;
  word_t             acc_r, err_r, pred_r, rd_r, act_r;
  logic [30:0]       sq_r;
  logic              bad_r;
  word_t             ow_r, a_r, herr_r, deriv_r, t_r, hd_r, w_r, t0_r, t1_r;
  logic [18:0]       frac_r;
  logic [HW-1:0]     j_r;
  logic [1:0]        i_r;
  logic [8:0]        addr_r;
  logic signed [63:0] prod_r;
  word_t             mul_a, mul_b, qm, xi, wrd, ard_r, lr_w;
  wram_req_t         req;
  word_t             acts [HIDDEN];
  logic              out_valid_r;
  word_t             o_pred_r, o_rd_r;
  logic [30:0]       o_sq_r;
  logic              o_bad_r;

  logic              last_j, last_i;
  logic signed [32:0] hv;
  logic [18:0]       ub;
  logic [TANH_SH-1:0] tidx;
  logic signed [63:0] tsum;

  assign last_j = (j_r == HW'(HIDDEN - 1));
  assign last_i = (i_r == 2'(FEATURES - 1));
  assign lr_w   = word_t'({15'd0, lr_r});
  assign qm     = qpost(prod_r);
  assign hv     = 33'(acc_r) + 33'(FOUR_Q16);
  assign ub     = hv[18:0];
  assign tidx   = ub[18 -: TANH_SH];
  assign tsum   = (prod_r + 64'sd262144) >>> 19;

  always_comb begin
    case (i_r)
      2'd0:    xi = x_r[0];
      2'd1:    xi = x_r[1];
      default: xi = x_r[2];
    endcase
  end

  mlpt_wram #(.DEPTH(WORDS)) u_wram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rdata (wrd)
  );

  // Activation store: written once per hidden unit before the output layer uses it.
  always_ff @(posedge clk) begin
    if (state_r == S_T_WR) begin
      acts[j_r] <= act_r;
    end
    ard_r <= acts[j_r];
  end

  // Operand selection for the shared multiplier and memory port.
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    req.we    = 1'b0;
    req.waddr = addr_r;
    req.wdata = '0;
    req.raddr = addr_r;
    unique case (state_r)
      S_HB_RD:  req.raddr = 9'(OFS_B) + 9'(j_r);
      S_HW_MUL: begin mul_a = xi; mul_b = wrd; end
      S_T_MUL:  begin mul_a = t1_r - t0_r; mul_b = word_t'({13'd0, frac_r}); end
      S_OB_RD:  req.raddr = 9'(OFS_OB);
      S_OW_RD:  req.raddr = 9'(OFS_O) + 9'(j_r);
      S_OW_MUL: begin mul_a = ard_r; mul_b = wrd; end
      S_SQ_MUL: begin mul_a = err_r; mul_b = err_r; end
      S_U_RD:   req.raddr = 9'(OFS_O) + 9'(j_r);
      S_U_HE:   begin mul_a = err_r; mul_b = wrd; end
      S_U_HE2:  begin mul_a = a_r; mul_b = a_r; end
      S_U_DV:   begin mul_a = err_r; mul_b = a_r; end
      S_U_GO:   begin mul_a = herr_r; mul_b = deriv_r; end
      S_U_HD:   begin mul_a = lr_w; mul_b = t_r; end
      S_U_OW: begin
        mul_a     = lr_w;
        mul_b     = hd_r;
        req.we    = 1'b1;
        req.waddr = 9'(OFS_O) + 9'(j_r);
        req.wdata = qsub(ow_r, qm);
        req.raddr = 9'(OFS_B) + 9'(j_r);
      end
      S_U_BW: begin
        req.we    = 1'b1;
        req.waddr = 9'(OFS_B) + 9'(j_r);
        req.wdata = qsub(wrd, qm);
      end
      S_U_IM1:  begin mul_a = hd_r; mul_b = xi; end
      S_U_IM2:  begin mul_a = lr_w; mul_b = qm; end
      S_U_IWR: begin
        req.we    = 1'b1;
        req.wdata = qsub(w_r, qm);
      end
      S_U_OB: begin
        mul_a     = lr_w;
        mul_b     = err_r;
        req.raddr = 9'(OFS_OB);
      end
      S_U_OBW: begin
        req.we    = 1'b1;
        req.waddr = 9'(OFS_OB);
        req.wdata = qsub(wrd, qm);
      end
      S_WR: begin
        req.we    = !bad_r;
        req.waddr = widx_r;
        req.wdata = wval_r;
      end
      S_RRD:    req.raddr = widx_r;
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_op[1]) state_nxt = S_HB_RD;
          else if (in_op[0]) state_nxt = S_RRD;
          else state_nxt = S_WR;
        end
      end
      S_HB_RD:  state_nxt = S_HB_LD;
      S_HB_LD:  state_nxt = S_HW_RD;
      S_HW_RD:  state_nxt = S_HW_MUL;
      S_HW_MUL: state_nxt = S_HW_ACC;
      S_HW_ACC: state_nxt = last_i ? S_T_IDX : S_HW_RD;
      S_T_IDX: begin
        if ((acc_r < -FOUR_Q16) || (acc_r >= FOUR_Q16)) state_nxt = S_T_WR;
        else state_nxt = S_T_MUL;
      end
      S_T_MUL:  state_nxt = S_T_ADD;
      S_T_ADD:  state_nxt = S_T_WR;
      S_T_WR:   state_nxt = last_j ? S_OB_RD : S_HB_RD;
      S_OB_RD:  state_nxt = S_OB_LD;
      S_OB_LD:  state_nxt = S_OW_RD;
      S_OW_RD:  state_nxt = S_OW_MUL;
      S_OW_MUL: state_nxt = S_OW_ACC;
      S_OW_ACC: state_nxt = last_j ? S_ERR : S_OW_RD;
      S_ERR:    state_nxt = S_SQ_MUL;
      S_SQ_MUL: state_nxt = S_SQ;
      S_SQ:     state_nxt = op_r[0] ? S_U_RD : S_DONE;
      S_U_RD:   state_nxt = S_U_HE;
      S_U_HE:   state_nxt = S_U_HE2;
      S_U_HE2:  state_nxt = S_U_DV;
      S_U_DV:   state_nxt = S_U_GO;
      S_U_GO:   state_nxt = S_U_HD;
      S_U_HD:   state_nxt = S_U_OW;
      S_U_OW:   state_nxt = S_U_BW;
      S_U_BW:   state_nxt = S_U_IRD;
      S_U_IRD:  state_nxt = S_U_IM1;
      S_U_IM1:  state_nxt = S_U_IM2;
      S_U_IM2:  state_nxt = S_U_IWR;
      S_U_IWR: begin
        if (!last_i) state_nxt = S_U_IRD;
        else if (last_j) state_nxt = S_U_OB;
        else state_nxt = S_U_RD;
      end
      S_U_OB:   state_nxt = S_U_OBW;
      S_U_OBW:  state_nxt = S_DONE;
      S_WR:     state_nxt = S_DONE;
      S_RRD:    state_nxt = S_RLD;
      S_RLD:    state_nxt = S_DONE;
      S_DONE:   state_nxt = (out_valid_r && out_stall) ? S_DONE : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lr_r        <= 17'd5243;
      out_valid_r <= 1'b0;
      j_r         <= '0;
      i_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) lr_r <= cfg_wr_data;
      if (state_r == S_DONE && !(out_valid_r && out_stall)) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE:   j_r <= '0;
        S_HB_LD:  i_r <= '0;
        S_HW_ACC: if (!last_i) i_r <= i_r + 2'd1;
        S_T_WR:   j_r <= last_j ? '0 : j_r + HW'(1);
        S_OW_ACC: j_r <= last_j ? '0 : j_r + HW'(1);
        S_U_BW:   i_r <= '0;
        S_U_IWR: begin
          if (!last_i) i_r <= i_r + 2'd1;
          else j_r <= last_j ? '0 : j_r + HW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    unique case (state_r)
      S_IDLE: begin
        op_r     <= in_op;
        x_r[0]   <= in_feature_a;
        x_r[1]   <= (FEATURES > 1) ? in_feature_b : '0;
        x_r[2]   <= (FEATURES > 2) ? in_feature_c : '0;
        target_r <= in_target;
        widx_r   <= in_weight_index;
        wval_r   <= in_weight_value;
        pred_r   <= '0;
        sq_r     <= '0;
        rd_r     <= '0;
        bad_r    <= in_op[1] && (10'(in_weight_index) >= 10'(WORDS));
      end
      S_HB_LD:  begin acc_r <= wrd; addr_r <= 9'(j_r); end
      S_HW_ACC: begin acc_r <= qadd(acc_r, qm); addr_r <= addr_r + 9'(HIDDEN); end
      S_T_IDX: begin
        if (acc_r < -FOUR_Q16) act_r <= -ONE_Q16;
        else act_r <= ONE_Q16;
        t0_r   <= TANH_TBL[tidx];
        t1_r   <= (tidx == TANH_SH'(TANH_DEPTH - 1)) ? ONE_Q16
                                                       : TANH_TBL[tidx + TANH_SH'(1)];
        frac_r <= ub << TANH_SH;
      end
      S_T_ADD:  act_r <= sat32(48'(t0_r) + tsum[47:0]);
      S_OB_LD:  acc_r <= wrd;
      S_OW_ACC: acc_r <= qadd(acc_r, qm);
      S_ERR: begin
        pred_r <= acc_r;
        err_r  <= qsub(acc_r, target_r);
      end
      S_SQ:     sq_r <= qm[31] ? '0 : qm[30:0];
      S_U_HE:   begin ow_r <= wrd; a_r <= ard_r; end
      S_U_HE2:  herr_r <= qm;
      S_U_DV:   deriv_r <= qsub(ONE_Q16, qm);
      S_U_GO:   t_r <= qm;
      S_U_HD:   hd_r <= qm;
      S_U_BW:   addr_r <= 9'(j_r);
      S_U_IM1:  w_r <= wrd;
      S_U_IWR:  addr_r <= addr_r + 9'(HIDDEN);
      S_RLD:    rd_r <= bad_r ? '0 : wrd;
      S_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          o_pred_r <= pred_r;
          o_sq_r   <= sq_r;
          o_rd_r   <= rd_r;
          o_bad_r  <= bad_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_prediction    = o_pred_r;
  assign out_squared_error = o_sq_r;
  assign out_read_value    = o_rd_r;
  assign out_index_bad     = o_bad_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block took a transaction without going busy");

  a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(j_r) < HIDDEN)
    else $error("hidden unit counter out of range");

  a_i_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(i_r) < FEATURES)
    else $error("feature counter out of range");

  a_bad_no_pred: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_index_bad) |-> (out_prediction == 0 && out_squared_error == 0))
    else $error("bad index result carries a prediction");

  a_write_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.we |-> (state_r != S_IDLE && state_r != S_DONE))
    else $error("weight store written outside a transaction");

endmodule

`default_nettype wire

// ----- dv/mlp_tanh_sgd_train_step_top_tb.sv -----
// ----------------------------------------------------------------------------
// mlp_tanh_sgd_train_step_top_tb: self-checking bench for the network trainer
// A queue-fed driver offers operations with random gaps. A monitor predicts
// every result with its own fixed point copy of the network and compares each
// returned transaction field by field. Random stalls and one long receiver
// hold are applied, and the learning rate is changed between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlp_tanh_sgd_train_step_top_tb;
  import mlpt_pkg::*;

  localparam int NH = 30;
  localparam int NF = 3;
  localparam int NWORDS = NF * NH + 2 * NH + 1;
  localparam int TDEPTH = 256;
  localparam int SETTLE = 1300;
  localparam int IDLE_LIMIT = 20000;
  localparam int LONG_HOLD = 2000;

  localparam logic [1:0] OP_PREDICT = 2'd0;
  localparam logic [1:0] OP_TRAIN   = 2'd1;
  localparam logic [1:0] OP_WRITE   = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  typedef struct {
    logic [1:0] op;
    word_t      fa, fb, fc, tgt;
    logic [8:0] widx;
    word_t      wval;
  } job_t;

  typedef struct {
    word_t       pred;
    logic [30:0] sq;
    word_t       rd;
    logic        bad;
  } answer_t;

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [16:0] cfg_wr_data;
  logic in_valid, in_stall;
  logic [1:0] in_op;
  logic signed [31:0] in_feature_a, in_feature_b, in_feature_c, in_target, in_weight_value;
  logic [8:0] in_weight_index;
  logic out_valid, out_stall;
  logic signed [31:0] out_prediction, out_read_value;
  logic [30:0] out_squared_error;
  logic out_index_bad;

  mlp_tanh_sgd_train_step_top dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_stall, .in_op, .in_feature_a, .in_feature_b, .in_feature_c,
    .in_target, .in_weight_index, .in_weight_value,
    .out_valid, .out_stall, .out_prediction, .out_squared_error,
    .out_read_value, .out_index_bad
  );

  // Network copy used for prediction.
  word_t w_in [NF*NH];
  word_t b_hid [NH];
  word_t w_out [NH];
  word_t b_out;
  word_t tanh_lut [TDEPTH];
  word_t lrate;

  job_t    pending_jobs [$];
  answer_t expected_answers [$];
  int      errors = 0;
  logic    in_acc = 0, out_acc = 0;
  int      send_gap = 0, recv_gap = 0, hold_left = 0;
  int      hold_req = 0, hold_seen = 0;
  bit      no_gaps = 0;
  int      idle_cycles = 0;

  function automatic word_t fx_sat(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return word_t'(v);
  endfunction

  function automatic word_t fx_mul(input word_t a, input word_t b);
    return fx_sat((longint'(a) * longint'(b) + 64'sd32768) >>> 16);
  endfunction

  function automatic word_t fx_add(input word_t a, input word_t b);
    return fx_sat(longint'(a) + longint'(b));
  endfunction

  function automatic word_t fx_sub(input word_t a, input word_t b);
    return fx_sat(longint'(a) - longint'(b));
  endfunction

  function automatic longint unsigned q30_mul(input longint unsigned x, y);
    return (x * y + (64'd1 << 29)) >> 30;
  endfunction

  task automatic fill_tanh_lut();
    longint unsigned term, sum, q, r, base, num, den, t;
    int m;
    int unsigned e;
    term = 64'd1 << 60;
    sum = term;
    for (int i = 1; i <= 20; i++) begin
      term = term * 64'd8 / (64'(i) * 64'(TDEPTH));
      if (i % 2) sum = sum - term;
      else sum = sum + term;
    end
    q = (sum + (64'd1 << 29)) >> 30;
    for (int k = 0; k < TDEPTH; k++) begin
      m = 2 * k - TDEPTH;
      e = (m < 0) ? -m : m;
      r = 64'd1 << 30;
      base = q;
      while (e != 0) begin
        if (e & 1) r = q30_mul(r, base);
        base = q30_mul(base, base);
        e = e >> 1;
      end
      num = ((64'd1 << 30) - r) << 16;
      den = (64'd1 << 30) + r;
      t = (num + den / 2) / den;
      tanh_lut[k] = (m < 0) ? -word_t'(t) : word_t'(t);
    end
  endtask

  function automatic word_t tanh_fx(input word_t h);
    longint p, idx, frac, t0, t1;
    if (h < -32'sd262144) return -32'sd65536;
    if (h >= 32'sd262144) return 32'sd65536;
    p = (longint'(h) + 262144) * TDEPTH;
    idx = p >>> 19;
    frac = p & 64'h7FFFF;
    t0 = tanh_lut[idx];
    t1 = (idx + 1 < TDEPTH) ? tanh_lut[idx+1] : 65536;
    return fx_sat(t0 + (((t1 - t0) * frac + (64'sd1 << 18)) >>> 19));
  endfunction

  // Runs one operation on the network copy and returns what the block should send.
  function automatic answer_t net_step(input job_t j);
    answer_t r;
    word_t x [NF];
    word_t act [NH];
    word_t acc, err, a, hd;
    int ix;
    r = '{pred: 0, sq: 0, rd: 0, bad: 0};
    x[0] = j.fa; x[1] = j.fb; x[2] = j.fc;
    if (j.op == OP_PREDICT || j.op == OP_TRAIN) begin
      for (int h = 0; h < NH; h++) begin
        acc = b_hid[h];
        for (int i = 0; i < NF; i++) acc = fx_add(acc, fx_mul(x[i], w_in[i*NH+h]));
        act[h] = tanh_fx(acc);
      end
      acc = b_out;
      for (int h = 0; h < NH; h++) acc = fx_add(acc, fx_mul(act[h], w_out[h]));
      r.pred = acc;
      err = fx_sub(acc, j.tgt);
      acc = fx_mul(err, err);
      r.sq = (acc < 0) ? 31'd0 : acc[30:0];
      if (j.op == OP_TRAIN) begin
        for (int h = 0; h < NH; h++) begin
          a = act[h];
          hd = fx_mul(fx_mul(err, w_out[h]), fx_sub(32'sd65536, fx_mul(a, a)));
          w_out[h] = fx_sub(w_out[h], fx_mul(lrate, fx_mul(err, a)));
          for (int i = 0; i < NF; i++)
            w_in[i*NH+h] = fx_sub(w_in[i*NH+h], fx_mul(lrate, fx_mul(hd, x[i])));
          b_hid[h] = fx_sub(b_hid[h], fx_mul(lrate, hd));
        end
        b_out = fx_sub(b_out, fx_mul(lrate, err));
      end
    end else begin
      ix = j.widx;
      if (ix >= NWORDS) begin
        r.bad = 1;
      end else if (j.op == OP_WRITE) begin
        if (ix < NF*NH) w_in[ix] = j.wval;
        else if (ix < NF*NH + NH) b_hid[ix-NF*NH] = j.wval;
        else if (ix < NF*NH + 2*NH) w_out[ix-NF*NH-NH] = j.wval;
        else b_out = j.wval;
      end else begin
        if (ix < NF*NH) r.rd = w_in[ix];
        else if (ix < NF*NH + NH) r.rd = b_hid[ix-NF*NH];
        else if (ix < NF*NH + 2*NH) r.rd = w_out[ix-NF*NH-NH];
        else r.rd = b_out;
      end
    end
    return r;
  endfunction

  function automatic word_t rand_feature();
    if ($urandom_range(0, 4) == 0) return word_t'($urandom);
    return word_t'($urandom_range(0, 655360)) - 32'sd327680;
  endfunction

  function automatic job_t rand_job();
    job_t j;
    int pick;
    pick = $urandom_range(0, 99);
    j.op = (pick < 30) ? OP_TRAIN : (pick < 55) ? OP_PREDICT : (pick < 80) ? OP_WRITE : OP_READ;
    j.fa = rand_feature();
    j.fb = rand_feature();
    j.fc = rand_feature();
    j.tgt = rand_feature();
    j.widx = ($urandom_range(0, 6) == 0) ? 9'($urandom_range(NWORDS, 511))
                                           : 9'($urandom_range(0, NWORDS - 1));
    if ($urandom_range(0, 5) == 0) j.wval = word_t'($urandom);
    else j.wval = word_t'($urandom_range(0, 131072)) - 32'sd65536;
    return j;
  endfunction

  function automatic job_t mk(input logic [1:0] op, input word_t fa, fb, fc, tgt,
                              input int widx, input word_t wval);
    job_t j;
    j.op = op; j.fa = fa; j.fb = fb; j.fc = fc; j.tgt = tgt;
    j.widx = 9'(widx); j.wval = wval;
    return j;
  endfunction

  task automatic add_job(input job_t j);
    pending_jobs.insert(pending_jobs.size(), j);
  endtask

  task automatic wait_idle();
    while (pending_jobs.size() != 0 || in_valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_rate(input logic [16:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    lrate = word_t'({15'd0, v});
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Driver: offers the next queued transaction after a random gap.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_acc)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_jobs.size() != 0) begin
        job_t j;
        j = pending_jobs.pop_front();
        in_op <= j.op;
        in_feature_a <= j.fa;
        in_feature_b <= j.fb;
        in_feature_c <= j.fc;
        in_target <= j.tgt;
        in_weight_index <= j.widx;
        in_weight_value <= j.wval;
        in_valid <= 1'b1;
        send_gap = no_gaps ? 0 : $urandom_range(0, 17);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall after each result, plus a long hold on request.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_acc) recv_gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: predicts on input acceptance and checks on output acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      in_acc <= in_valid && !in_stall;
      out_acc <= out_valid && !out_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (in_valid && !in_stall)
        expected_answers.insert(expected_answers.size(), net_step(mk(in_op, in_feature_a,
          in_feature_b, in_feature_c, in_target, in_weight_index, in_weight_value)));
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          answer_t e;
          e = expected_answers.pop_front();
          if (out_prediction !== e.pred) begin
            $error("prediction: expected %0d, got %0d", e.pred, out_prediction);
            errors++;
          end
          if (out_squared_error !== e.sq) begin
            $error("squared_error: expected %0d, got %0d", e.sq, out_squared_error);
            errors++;
          end
          if (out_read_value !== e.rd) begin
            $error("read_value: expected %0d, got %0d", e.rd, out_read_value);
            errors++;
          end
          if (out_index_bad !== e.bad) begin
            $error("index_bad: expected %0d, got %0d", e.bad, out_index_bad);
            errors++;
          end
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [16:0] rates [4];
    word_t pmax, pmin;
    pmax = 32'sh7FFF_FFFF;
    pmin = 32'sh8000_0000;
    rates = '{17'h10000, 17'd0, 17'd1, 17'($urandom_range(1, 65535))};
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    in_valid = 0;
    in_op = OP_PREDICT;
    in_feature_a = 0; in_feature_b = 0; in_feature_c = 0; in_target = 0;
    in_weight_index = 0;
    in_weight_value = 0;
    out_stall = 0;
    for (int i = 0; i < NF*NH; i++) w_in[i] = 0;
    for (int i = 0; i < NH; i++) begin
      b_hid[i] = 0;
      w_out[i] = 0;
    end
    b_out = 0;
    lrate = 32'sd5243;
    fill_tanh_lut();
    repeat (11) @(negedge clk);
    rst_n = 1;

    // Directed: zero network, table edges, every region of the weight map,
    // bad indexes, saturating sums and errors.
    add_job(mk(OP_PREDICT, 0, 0, 0, 0, 0, 0));
    add_job(mk(OP_READ, 0, 0, 0, 0, 0, 0));
    add_job(mk(OP_WRITE, 0, 0, 0, 0, 0, 32'sd65536));
    add_job(mk(OP_WRITE, 0, 0, 0, 0, 89, pmin));
    add_job(mk(OP_WRITE, 0, 0, 0, 0, 90, 32'sd131072));
    add_job(mk(OP_WRITE, 0, 0, 0, 0, 119, pmax));
    add_job(mk(OP_WRITE, 0, 0, 0, 0, 120, 32'sd98304));
    add_job(mk(OP_WRITE, 0, 0, 0, 0, 149, -32'sd40000));
    add_job(mk(OP_WRITE, 0, 0, 0, 0, NWORDS - 1, 32'sd1000));
    add_job(mk(OP_WRITE, 0, 0, 0, 0, NWORDS, pmax));
    add_job(mk(OP_WRITE, 0, 0, 0, 0, 511, pmin));
    add_job(mk(OP_READ, 0, 0, 0, 0, 89, 0));
    add_job(mk(OP_READ, 0, 0, 0, 0, NWORDS - 1, 0));
    add_job(mk(OP_READ, 0, 0, 0, 0, NWORDS, 0));
    add_job(mk(OP_READ, 0, 0, 0, 0, 511, 0));
    add_job(mk(OP_PREDICT, -32'sd262144, 32'sd262143, 32'sd65536, 0, 0, 0));
    add_job(mk(OP_PREDICT, pmax, pmin, pmax, pmin, 0, 0));
    add_job(mk(OP_TRAIN, 32'sd65536, -32'sd32768, 32'sd16384, 32'sd65536, 0, 0));
    add_job(mk(OP_TRAIN, pmin, pmax, -1, pmax, 0, 0));
    add_job(mk(OP_TRAIN, -32'sd262145, 32'sd262144, 0, pmin, 0, 0));
    add_job(mk(OP_PREDICT, 32'sd30000, 32'sd20000, -32'sd10000, 0, 0, 0));
    add_job(mk(OP_READ, 0, 0, 0, 0, 120, 0));
    for (int k = 0; k < 250; k++) add_job(rand_job());

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      set_rate(rates[ph]);
      no_gaps = (ph == 2);
      for (int k = 0; k < 250; k++) add_job(rand_job());
      // The receiver holds off while the sender keeps offering, so the block fills.
      if (ph == 1) hold_req++;
    end

    while (pending_jobs.size() != 0 || in_valid || expected_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
